>>> rtl/bus_pkg.sv
`default_nettype none
package bus_pkg;

    localparam int BUS_DEPTH = 16;
    localparam int BUS_IDX_W = (BUS_DEPTH > 1) ? $clog2(BUS_DEPTH) : 1;
    localparam int BUS_CNT_W = $clog2(BUS_DEPTH + 1);
    localparam int BUS_CAP_W = 5;
    localparam int BUS_VAL_W = 32;
    localparam int BUS_REQ_W = 2;

    localparam int BUS_IN_BITS  = BUS_REQ_W + BUS_VAL_W;
    localparam int BUS_IN_W     = ((BUS_IN_BITS + 7) / 8) * 8;
    localparam int BUS_OUT_BITS = 1 + BUS_CNT_W + 1;
    localparam int BUS_OUT_W    = ((BUS_OUT_BITS + 7) / 8) * 8;

    localparam logic [BUS_REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [BUS_REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [BUS_REQ_W-1:0] REQ_QUERY  = 2'd2;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    localparam logic [BUS_CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [BUS_VAL_W-1:0] val_t;
    typedef logic [BUS_CNT_W-1:0] cnt_t;
    typedef logic [BUS_IDX_W-1:0] idx_t;

    typedef struct packed {
        val_t value;
        cnt_t count;
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/bus_cell.sv
`default_nettype none
module bus_cell (
    input  wire                 aclk,
    input  bus_pkg::cell_ctrl_t ctrl,
    input  bus_pkg::idx_t       cell_idx,
    input  wire                 hit_in,
    output logic                hit_out,
    input  bus_pkg::val_t       right_entry,
    output bus_pkg::val_t       entry_out
);

    bus_pkg::val_t entry_reg;
    bus_pkg::cnt_t my_pos;
    logic          active;
    logic          hit;

    assign my_pos    = bus_pkg::cnt_t'(cell_idx);
    assign active    = my_pos < ctrl.count;
    assign hit       = active && (entry_reg == ctrl.value);
    assign hit_out   = hit_in | hit;
    assign entry_out = entry_reg;

    // removal shifts every held entry at or after the match down one place; an insert fills the first free cell
    always_ff @(posedge aclk) begin
        if (ctrl.rem_en && hit_out && active) begin
            entry_reg <= right_entry;
        end else if (ctrl.ins_en && (ctrl.count == my_pos)) begin
            entry_reg <= ctrl.value;
        end
    end

endmodule
`default_nettype wire

>>> rtl/bounded_unique_set_core.sv
`default_nettype none
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | s_tdata: req_type, value
// m_      | out       | m_tvalid/m_tready  | m_tdata: was_present, entry_count, status
// cfg_    | in        | cfg_we             | cfg_wdata: capacity
//
// one word per cycle: all cells compare at once, a match ripples along the chain
// and the held entries shift down in the same cycle
// the result is registered in the output register on acceptance
// a new word is taken while the output register is empty or its result is being taken; a stalled result stalls input
// reset clears the count; entries need no clearing
module bounded_unique_set_core (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // req_type [1:0], value [33:2]
    input  wire  [bus_pkg::BUS_IN_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // was_present [0], entry_count [5:1], status [6]
    output logic [bus_pkg::BUS_OUT_W-1:0]  m_tdata,
    input  wire                            cfg_we,
    input  wire  [bus_pkg::BUS_CAP_W-1:0]  cfg_wdata
);

    logic [bus_pkg::BUS_CAP_W-1:0] cap_reg;
    bus_pkg::cnt_t                 count_reg;
    bus_pkg::cnt_t                 count_next;
    logic                          m_tvalid_reg;
    logic [bus_pkg::BUS_OUT_W-1:0] m_tdata_reg;
    logic [bus_pkg::BUS_OUT_W-1:0] m_tdata_next;

    logic [bus_pkg::BUS_REQ_W-1:0] req_type;
    bus_pkg::val_t                 req_value;
    logic                          accept;
    logic                          present;
    logic                          full;
    logic                          status;
    bus_pkg::cnt_t                 eff_cap;
    bus_pkg::cell_ctrl_t           ctrl;

    logic          hit_chain [0:bus_pkg::BUS_DEPTH];
    bus_pkg::val_t cell_entry [0:bus_pkg::BUS_DEPTH];

    assign req_type  = s_tdata[bus_pkg::BUS_REQ_W-1:0];
    assign req_value = s_tdata[bus_pkg::BUS_REQ_W +: bus_pkg::BUS_VAL_W];
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign eff_cap = (cap_reg > bus_pkg::BUS_CAP_W'(bus_pkg::BUS_DEPTH))
                   ? bus_pkg::cnt_t'(bus_pkg::BUS_DEPTH)
                   : bus_pkg::cnt_t'(cap_reg);
    assign full    = count_reg >= eff_cap;
    assign present = hit_chain[bus_pkg::BUS_DEPTH];

    assign ctrl.value  = req_value;
    assign ctrl.count  = count_reg;
    assign ctrl.ins_en = accept && (req_type == bus_pkg::REQ_INSERT) && !full && !present;
    assign ctrl.rem_en = accept && (req_type == bus_pkg::REQ_REMOVE) && present;

    assign hit_chain[0]                    = 1'b0;
    assign cell_entry[bus_pkg::BUS_DEPTH]  = '0;

    for (genvar i = 0; i < bus_pkg::BUS_DEPTH; i++) begin : g_cell
        bus_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .cell_idx    (bus_pkg::BUS_IDX_W'(i)),
            .hit_in      (hit_chain[i]),
            .hit_out     (hit_chain[i+1]),
            .right_entry (cell_entry[i+1]),
            .entry_out   (cell_entry[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        status     = bus_pkg::ST_OK;
        if (accept && (req_type == bus_pkg::REQ_INSERT) && full) begin
            status = bus_pkg::ST_FULL;
        end
        if (ctrl.ins_en) begin
            count_next = count_reg + bus_pkg::cnt_t'(1);
        end else if (ctrl.rem_en) begin
            count_next = count_reg - bus_pkg::cnt_t'(1);
        end
        m_tdata_next = '0;
        m_tdata_next[0] = present;
        m_tdata_next[1 +: bus_pkg::BUS_CNT_W] = count_next;
        m_tdata_next[1 + bus_pkg::BUS_CNT_W] = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= bus_pkg::CAP_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // count never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bus_pkg::cnt_t'(bus_pkg::BUS_DEPTH))
        else $error("count beyond depth");

    // the pending word reports the count now held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[1 +: bus_pkg::BUS_CNT_W] == count_reg))
        else $error("reported count differs from held count");

    // a rejected insert leaves the count alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (req_type == bus_pkg::REQ_INSERT) && full) |=> $stable(count_reg))
        else $error("full insert changed count");

    // a successful removal drops the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rem_en |=> (count_reg == $past(count_reg) - bus_pkg::cnt_t'(1)))
        else $error("removal count mismatch");

endmodule
`default_nettype wire

>>> tb/tb_bounded_unique_set_core.sv
`timescale 1ns / 100ps
module tb_bounded_unique_set_core;

    localparam logic [bus_pkg::BUS_REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int LONG_STALL  = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int POOL_SIZE   = 20;

    typedef struct packed {
        logic          was_present;
        bus_pkg::cnt_t count;
        logic          status;
    } answer_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [bus_pkg::BUS_IN_W-1:0]   s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [bus_pkg::BUS_OUT_W-1:0]  m_tdata;
    logic                           cfg_we    = 1'b0;
    logic [bus_pkg::BUS_CAP_W-1:0]  cfg_wdata = bus_pkg::CAP_RESET;

    // predicted contents of the set
    bus_pkg::val_t set_vals [bus_pkg::BUS_DEPTH];
    int            held    = 0;
    int            cap_now = int'(bus_pkg::CAP_RESET);

    logic [bus_pkg::BUS_IN_W-1:0] request_words [$];
    answer_t                      pending_answers [$];
    bus_pkg::val_t                value_pool [POOL_SIZE];

    int send_idle_pct  = 19;
    int recv_idle_pct  = 75;
    int stall_requests = 0;
    int stalls_done    = 0;
    int stall_left     = 0;
    int n_requests     = 0;
    int n_results      = 0;
    int n_hits         = 0;
    int n_full         = 0;
    int n_errors       = 0;
    int quiet          = 0;

    bounded_unique_set_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic answer_t update_set(logic [bus_pkg::BUS_REQ_W-1:0] req,
                                           bus_pkg::val_t v);
        answer_t a;
        int pos;
        int room;
        pos = held;
        for (int i = held - 1; i >= 0; i--) begin
            if (set_vals[i] == v) pos = i;
        end
        room = (cap_now < bus_pkg::BUS_DEPTH) ? cap_now : bus_pkg::BUS_DEPTH;
        a.was_present = (pos < held);
        a.status = bus_pkg::ST_OK;
        if (req == bus_pkg::REQ_INSERT) begin
            if (held >= room) begin
                a.status = bus_pkg::ST_FULL;
            end else if (!a.was_present) begin
                set_vals[held] = v;
                held++;
            end
        end else if (req == bus_pkg::REQ_REMOVE && a.was_present) begin
            for (int j = pos; j < held - 1; j++) set_vals[j] = set_vals[j + 1];
            held--;
        end
        a.count = bus_pkg::cnt_t'(held);
        return a;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("mismatch in %s on result %0d: got %0h, wanted %0h",
                 field, n_results, got, want);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            held = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_answers.push_back(
                    update_set(s_tdata[bus_pkg::BUS_REQ_W-1:0],
                               s_tdata[bus_pkg::BUS_REQ_W +: bus_pkg::BUS_VAL_W]));
                n_requests++;
                if (pending_answers[$].was_present) n_hits++;
                if (pending_answers[$].status == bus_pkg::ST_FULL) n_full++;
            end
            if (!s_tvalid || s_tready) begin
                if (request_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= request_words.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : result_check
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected word", 32'(m_tdata), 32'd0);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata[0] !== want.was_present)
                    report_mismatch("was_present", 32'(m_tdata[0]), 32'(want.was_present));
                if (m_tdata[bus_pkg::BUS_CNT_W:1] !== want.count)
                    report_mismatch("entry_count", 32'(m_tdata[bus_pkg::BUS_CNT_W:1]),
                                    32'(want.count));
                if (m_tdata[bus_pkg::BUS_CNT_W+1] !== want.status)
                    report_mismatch("status", 32'(m_tdata[bus_pkg::BUS_CNT_W+1]),
                                    32'(want.status));
            end
        end
        if (stall_requests != stalls_done) begin
            stalls_done++;
            stall_left = LONG_STALL;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_request(logic [bus_pkg::BUS_REQ_W-1:0] req, bus_pkg::val_t v);
        request_words.push_back({{(bus_pkg::BUS_IN_W - bus_pkg::BUS_IN_BITS){1'b0}}, v, req});
    endtask

    // checked away from the rising edge so every handshake of that edge has settled
    task automatic wait_idle();
        do @(negedge aclk);
        while (request_words.size() != 0 || s_tvalid || pending_answers.size() != 0);
    endtask

    task automatic write_capacity(logic [bus_pkg::BUS_CAP_W-1:0] c);
        wait_idle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        cap_now = int'(c);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic bus_pkg::val_t pick_value();
        if ($urandom_range(7) == 0) return $urandom();
        return value_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    task automatic run_segment(int n, int ins_pct, int rem_pct);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < ins_pct) add_request(bus_pkg::REQ_INSERT, pick_value());
            else if (r < ins_pct + rem_pct) add_request(bus_pkg::REQ_REMOVE, pick_value());
            else if (r < 95) add_request(bus_pkg::REQ_QUERY, pick_value());
            else add_request(REQ_SPARE, pick_value());
        end
    endtask

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // empty set, extremes, present insert, last and first removal
        add_request(bus_pkg::REQ_QUERY,  32'h0000_0000);
        add_request(bus_pkg::REQ_REMOVE, 32'h0000_0005);
        add_request(bus_pkg::REQ_INSERT, 32'h8000_0000);
        add_request(bus_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        add_request(bus_pkg::REQ_INSERT, 32'h0000_0000);
        add_request(bus_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        add_request(bus_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        add_request(bus_pkg::REQ_QUERY,  32'h8000_0000);
        add_request(REQ_SPARE,           32'hFFFF_FFFF);
        add_request(bus_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
        add_request(bus_pkg::REQ_REMOVE, 32'h8000_0000);
        add_request(bus_pkg::REQ_REMOVE, 32'h0000_0005);

        // capacity below count
        write_capacity(5'd1);
        add_request(bus_pkg::REQ_INSERT, 32'h0000_0000);
        add_request(bus_pkg::REQ_INSERT, 32'h0000_0007);
        add_request(bus_pkg::REQ_REMOVE, 32'h7FFF_FFFF);
        add_request(bus_pkg::REQ_REMOVE, 32'h0000_0000);
        add_request(bus_pkg::REQ_INSERT, 32'h0000_0007);
        add_request(bus_pkg::REQ_INSERT, 32'h0000_0008);

        // zero capacity refuses every insert
        write_capacity(5'd0);
        add_request(bus_pkg::REQ_INSERT, 32'h0000_0009);
        add_request(bus_pkg::REQ_QUERY,  32'h0000_0007);
        add_request(bus_pkg::REQ_REMOVE, 32'h0000_0007);

        // capacity above depth, fill to depth and overflow
        write_capacity(5'd31);
        for (int k = 0; k < bus_pkg::BUS_DEPTH + 1; k++)
            add_request(bus_pkg::REQ_INSERT,
                        bus_pkg::val_t'(k) * 32'h0F0F_0F0F + 32'h0000_0042);

        write_capacity(5'd16);
        run_segment(50, 40, 35);
        write_capacity(5'd4);
        stall_requests++;
        run_segment(50, 40, 35);
        write_capacity(5'd31);
        run_segment(50, 60, 25);

        wait_idle();
        send_idle_pct = 75;
        recv_idle_pct = 19;
        write_capacity(5'd1);
        run_segment(50, 40, 35);
        write_capacity(5'd0);
        run_segment(50, 40, 40);
        write_capacity(5'd16);
        run_segment(50, 65, 20);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(5'($urandom_range(15, 2)));
        run_segment(50, 50, 30);
        write_capacity(5'd2);
        run_segment(50, 45, 35);

        wait_idle();
        repeat (4) @(posedge aclk);
        $display("covered %0d requests and %0d result words: %0d hits, %0d inserts refused",
                 n_requests, n_results, n_hits, n_full);
        $display("capacities 0, 1, 2, 4, 16, 31 and one random, with idling, stalls and full rate");
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
